// ----- design/bcd_binary_converter_macros.svh -----
// Assertion macros shared by the converter RTL.
`ifndef BCD_BINARY_CONVERTER_MACROS_SVH
`define BCD_BINARY_CONVERTER_MACROS_SVH

// Same-cycle implication, checked on clk outside reset
`define BBC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk outside reset
`define BBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/bbc_pkg.sv -----
// Types, constants and step functions of the BCD / binary converter.
`default_nettype none

package bbc_pkg;

	localparam int WORD_W          = 32;
	localparam int NIB_W           = 4;
	localparam int NIBS            = WORD_W / NIB_W;
	localparam int BCD_DIGITS      = 10;                 // digits of the largest 32-bit value
	localparam int BCD_W           = BCD_DIGITS * NIB_W;
	localparam int NSTAGE          = 4;                  // conversion stages
	localparam int BITS_PER_STAGE  = WORD_W / NSTAGE;
	localparam int NIBS_PER_STAGE  = NIBS / NSTAGE;
	localparam logic [NIB_W-1:0] NIB_MAX     = 4'd9;
	localparam logic [NIB_W-1:0] DABBLE_MIN  = 4'd5;
	localparam logic [NIB_W-1:0] DABBLE_ADD  = 4'd3;

	localparam logic CMD_TO_BCD = 1'b0;
	localparam logic CMD_TO_BIN = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [WORD_W-1:0] value_in;
	} req_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] value_out;
		logic              all_decimal;
		logic              digits_lost;
	} rsp_item_t;

	// 1 when every nibble of the word is a decimal digit
	function automatic logic word_all_decimal(input logic [WORD_W-1:0] w);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < NIBS; i++) begin
			if (w[NIB_W*i +: NIB_W] > NIB_MAX) ok = 1'b0;
		end
		return ok;
	endfunction

	// One double-dabble step: correct each digit, then shift in one bit
	function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] acc,
							 input logic b);
		logic [BCD_W-1:0] fix;
		fix = acc;
		for (int d = 0; d < BCD_DIGITS; d++) begin
			if (fix[NIB_W*d +: NIB_W] >= DABBLE_MIN)
				fix[NIB_W*d +: NIB_W] = fix[NIB_W*d +: NIB_W] + DABBLE_ADD;
		end
		return {fix[BCD_W-2:0], b};
	endfunction

	// Binary to BCD: the binary bits handled by one stage, MSB first
	function automatic logic [BCD_W-1:0] dabble_stage(input logic [BCD_W-1:0] acc,
							  input logic [WORD_W-1:0] v,
							  input int stage);
		logic [BCD_W-1:0] a;
		int idx;
		a = acc;
		for (int j = 0; j < BITS_PER_STAGE; j++) begin
			idx = WORD_W - 1 - BITS_PER_STAGE * stage - j;
			a = dabble_step(a, v[idx]);
		end
		return a;
	endfunction

	// BCD to binary: Horner steps acc = acc*10 + nibble for one stage
	function automatic logic [WORD_W-1:0] horner_stage(input logic [WORD_W-1:0] acc,
							   input logic [WORD_W-1:0] v,
							   input int stage,
							   input int digits);
		logic [WORD_W-1:0] a;
		logic [NIB_W-1:0]  nib;
		int idx;
		a = acc;
		for (int j = 0; j < NIBS_PER_STAGE; j++) begin
			idx = NIBS - 1 - NIBS_PER_STAGE * stage - j;
			nib = (idx < digits) ? v[NIB_W*idx +: NIB_W] : '0;
			a = (a << 3) + (a << 1) + WORD_W'(nib);
		end
		return a;
	endfunction

endpackage

`default_nettype wire

// ----- design/bcd_binary_converter.sv -----
// Pipelined 32-bit binary <-> packed BCD converter, top level.
//
//  channel | valid     | stall     | payload              | direction
//  --------+-----------+-----------+----------------------+----------
//  request | req_valid | req_stall | req (req_item_t)     | in
//  result  | rsp_valid | rsp_stall | rsp (rsp_item_t)     | out
//
// One item per cycle unless a stalled result has backed up to the request.
// The 32 double-dabble shifts are split 8 per stage over four stages, the
// BCD-to-binary Horner sum 2 nibbles per stage; a fifth stage masks and flags.
// Every stage has its own valid bit and ready term, so bubbles close up and a
// stalled result keeps the stages behind it filling until they are full.
// Reset clears the valid bits only.
`default_nettype none

module bcd_binary_converter #(
	parameter int DIGITS = 8
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     req_valid,
	output logic                    req_stall,
	input  wire bbc_pkg::req_item_t req,
	output logic                    rsp_valid,
	input  wire                     rsp_stall,
	output bbc_pkg::rsp_item_t      rsp
);

	localparam int NS   = bbc_pkg::NSTAGE;
	localparam int KEEP = (DIGITS < bbc_pkg::BCD_DIGITS) ? DIGITS : bbc_pkg::BCD_DIGITS;
	localparam logic [bbc_pkg::BCD_W-1:0] KEEP_MASK =
		(bbc_pkg::BCD_W'(1) << (bbc_pkg::NIB_W * KEEP)) - bbc_pkg::BCD_W'(1);

	// valid bits: NS+1 is the result register
	logic [NS+1:1] vld_s;
	// valid entering each stage: index 0 is the request
	logic [NS:0]   vld_prev;
	logic [NS+2:1] rdy;

	logic                        cmd_s [1:NS+1];
	logic [bbc_pkg::WORD_W-1:0]  val_s [1:NS];
	logic [bbc_pkg::BCD_W-1:0]   acc_s [1:NS];
	bbc_pkg::rsp_item_t          rsp_s5;

	assign vld_prev = {vld_s[NS:1], req_valid};

	// ready chain from the result side back to the request
	assign rdy[NS+2] = !rsp_stall;
	for (genvar k = 1; k <= NS + 1; k++) begin : g_rdy
		assign rdy[k] = !vld_s[k] || rdy[k+1];
	end
	assign req_stall = !rdy[1];

	// valid bits
	for (genvar k = 1; k <= NS + 1; k++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= vld_prev[k-1];
			end
		end
	end

	// conversion stages
	for (genvar k = 1; k <= NS; k++) begin : g_stage
		logic                       cmd_in;
		logic [bbc_pkg::WORD_W-1:0] val_in;
		logic [bbc_pkg::BCD_W-1:0]  acc_in;
		logic [bbc_pkg::BCD_W-1:0]  acc_nx;
		logic [bbc_pkg::WORD_W-1:0] sum_nx;

		if (k == 1) begin : g_first
			assign cmd_in = req.cmd;
			assign val_in = req.value_in;
			assign acc_in = '0;
		end else begin : g_next
			assign cmd_in = cmd_s[k-1];
			assign val_in = val_s[k-1];
			assign acc_in = acc_s[k-1];
		end

		// one share of the chosen conversion
		always_comb begin
			sum_nx = bbc_pkg::horner_stage(acc_in[bbc_pkg::WORD_W-1:0], val_in, k - 1,
				DIGITS);
			if (cmd_in == bbc_pkg::CMD_TO_BIN) begin
				acc_nx = bbc_pkg::BCD_W'(sum_nx);
			end else begin
				acc_nx = bbc_pkg::dabble_stage(acc_in, val_in, k - 1);
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && vld_prev[k-1]) begin
				cmd_s[k] <= cmd_in;
				val_s[k] <= val_in;
				acc_s[k] <= acc_nx;
			end
		end
	end

	// result stage: for BCD results keep DIGITS digits, flag dropped ones
	logic [bbc_pkg::BCD_W-1:0] kept_bcd;
	bbc_pkg::rsp_item_t        rsp_nx;

	always_comb begin
		kept_bcd = acc_s[NS] & KEEP_MASK;
		rsp_nx.all_decimal = bbc_pkg::word_all_decimal(val_s[NS]);
		if (cmd_s[NS] == bbc_pkg::CMD_TO_BIN) begin
			rsp_nx.value_out   = acc_s[NS][bbc_pkg::WORD_W-1:0];
			rsp_nx.digits_lost = 1'b0;
		end else begin
			rsp_nx.value_out   = kept_bcd[bbc_pkg::WORD_W-1:0];
			rsp_nx.digits_lost = |(acc_s[NS] & ~KEEP_MASK);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NS+1] && vld_s[NS]) begin
			cmd_s[NS+1] <= cmd_s[NS];
			rsp_s5      <= rsp_nx;
		end
	end

	assign rsp_valid = vld_s[NS+1];
	assign rsp       = rsp_s5;

	// checks
	logic rsp_to_bin;
	logic rsp_bcd_ok;

	assign rsp_to_bin = (cmd_s[NS+1] == bbc_pkg::CMD_TO_BIN);
	assign rsp_bcd_ok = bbc_pkg::word_all_decimal(rsp.value_out);

`include "bcd_binary_converter_macros.svh"

	`BBC_ASSERT_NEXT(a_accept_fills_s1, req_valid && !req_stall, vld_s[1], "accepted item lost")
	`BBC_ASSERT_NOW(a_full_blocks, (&vld_s) && rsp_stall, req_stall, "request taken while full")
	`BBC_ASSERT_NOW(a_bin_no_lost, rsp_valid && rsp_to_bin, !rsp.digits_lost, "lost digits on BCD in")
	`BBC_ASSERT_NOW(a_bcd_decimal, rsp_valid && !rsp_to_bin, rsp_bcd_ok, "non-decimal BCD digit")

endmodule

`default_nettype wire
